// ----- src/msq_pkg.sv -----
// msq_pkg: widths, defaults and the sample threshold test for the
// marching-squares cell classifier. No dependencies.
package msq_pkg;

  localparam int MAX_GRID_COLS_DEF = 1024;
  localparam int MAX_GRID_ROWS_DEF = 1024;

  localparam int PIX_W   = 8;
  localparam int CASE_W  = 4;
  localparam int COORD_W = 10;
  localparam int SUM_W   = 10;

  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd128;

  typedef logic [PIX_W-1:0] pix_t;

  // floor((r+g+b)/3) > thr  <=>  r+g+b > 3*thr + 2
  function automatic logic sample_bit(pix_t r, pix_t g, pix_t b, pix_t thr);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] limit;
    sum   = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
    limit = SUM_W'(thr) + SUM_W'({thr, 1'b0}) + SUM_W'(2);
    return (sum > limit) ? 1'b0 : 1'b1;
  endfunction

endpackage

// ----- src/marching_squares_cell_classifier.sv -----
// marching_squares_cell_classifier: top level of the cell classifier.
// Depends on msq_pkg and msq_ram (line store of the previous row's bits).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one sampled grid pixel per
//   request in raster order, with row_end on the last sample of each row and
//   grid_end_row held for the whole final row. Each sample is thresholded to
//   one bit against the threshold register (cfg_we/cfg_wdata, reset 128).
//   Output channel (out_valid/out_ready) carries one request per sample that
//   lies past row 0 and column 0: the 4-bit case of the cell to its upper
//   left and that cell's top-left coordinates. Other samples give nothing.
//   A sample is registered in the input stage, with the line store read
//   alongside it, and is then classified into the output register.
//   Throughput: one sample per cycle, sustained, while out_ready stays high;
//   the line store has one read and one write port, used once per sample.
//   When the receiver stalls, the output register holds its request, one
//   more sample waits in the input stage, and then in_ready drops.
//   Reset clears counters, neighbour bits and the line store fill mark (line
//   store entries not yet written read as 0); no clearing pass is needed.
module marching_squares_cell_classifier #(
  parameter int MAX_GRID_COLS = msq_pkg::MAX_GRID_COLS_DEF,
  parameter int MAX_GRID_ROWS = msq_pkg::MAX_GRID_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  msq_pkg::pix_t               cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  msq_pkg::pix_t               red,
  input  msq_pkg::pix_t               green,
  input  msq_pkg::pix_t               blue,
  input  logic                        row_end,
  input  logic                        grid_end_row,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [msq_pkg::CASE_W-1:0]  case_index,
  output logic [msq_pkg::COORD_W-1:0] cell_row,
  output logic [msq_pkg::COORD_W-1:0] cell_col
);

  import msq_pkg::*;

  localparam int CW = $clog2(MAX_GRID_COLS);
  localparam int RW = $clog2(MAX_GRID_ROWS);
  localparam int FW = $clog2(MAX_GRID_COLS + 1);
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_GRID_COLS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(MAX_GRID_ROWS - 1);

  pix_t threshold;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [FW-1:0] fill;
  logic          left_bit;
  logic          upper_left_bit;

  // input stage
  logic          s1_valid;
  pix_t          s1_red, s1_green, s1_blue;
  logic          s1_row_end, s1_last_row;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic          s1_byp_hit, s1_byp_bit, s1_filled;

  logic          accept, s1_move, s1_produce, s1_bit, above, rdata;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_m1;
  logic [RW-1:0] row_m1;

  assign accept     = in_valid && in_ready;
  assign s1_produce = (s1_row != '0) && (s1_col != '0);
  assign s1_move    = s1_valid && (!s1_produce || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_move;

  assign s1_bit = sample_bit(s1_red, s1_green, s1_blue, threshold) &
                  !(s1_row_end && s1_last_row);
  assign above  = s1_byp_hit ? s1_byp_bit : (s1_filled & rdata);
  assign col_m1 = s1_col - CW'(1);
  assign row_m1 = s1_row - RW'(1);

  always_comb begin
    col_next = col_count;
    row_next = row_count;
    if (row_end) begin
      col_next = '0;
      if (grid_end_row) begin
        row_next = '0;
      end else if (row_count != ROW_LAST) begin
        row_next = row_count + RW'(1);
      end
    end else if (col_count != COL_LAST) begin
      col_next = col_count + CW'(1);
    end
  end

  msq_ram #(
    .WIDTH(1),
    .DEPTH(MAX_GRID_COLS)
  ) u_line (
    .clk  (clk),
    .we   (s1_move),
    .waddr(s1_col),
    .wdata(s1_bit),
    .re   (accept),
    .raddr(col_count),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count      <= '0;
      row_count      <= '0;
      fill           <= '0;
      left_bit       <= 1'b0;
      upper_left_bit <= 1'b0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        col_count <= col_next;
        row_count <= row_next;
        s1_valid  <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        left_bit       <= s1_bit;
        upper_left_bit <= above;
        // entries written since reset always form a prefix of the line
        if (FW'(s1_col) + FW'(1) > fill) begin
          fill <= FW'(s1_col) + FW'(1);
        end
      end
      if (s1_move && s1_produce) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_red      <= red;
      s1_green    <= green;
      s1_blue     <= blue;
      s1_row_end  <= row_end;
      s1_last_row <= grid_end_row;
      s1_col      <= col_count;
      s1_row      <= row_count;
      // the RAM returns old data when the leaving sample writes the same column
      s1_byp_hit  <= s1_move && (s1_col == col_count);
      s1_byp_bit  <= s1_bit;
      s1_filled   <= FW'(col_count) < fill;
    end
    if (s1_move && s1_produce) begin
      case_index <= {upper_left_bit, above, s1_bit, left_bit};
      cell_row   <= COORD_W'(row_m1);
      cell_col   <= COORD_W'(col_m1);
    end
  end

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted sample did not reach the input stage");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (col_count <= COL_LAST) && (row_count <= ROW_LAST))
    else $error("position counter beyond grid limit");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(MAX_GRID_COLS))
    else $error("line store fill mark beyond depth");

  a_out_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_move && s1_produce))
    else $error("result appeared without a classified sample");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_col) && $stable(s1_row))
    else $error("stalled sample lost from the input stage");

endmodule

// ----- src/msq_ram.sv -----
// msq_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module msq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- verif/marching_squares_cell_classifier_tb.sv -----
// Testbench for marching_squares_cell_classifier: drives sampled grid pixels,
// predicts each cell case in a local model and checks every result request.
// Depends on msq_pkg and the classifier RTL only.
module marching_squares_cell_classifier_tb;
  import msq_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_SHOWN   = 30;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    logic row_end;
    logic last_row;
  } sample_t;

  typedef struct packed {
    logic [CASE_W-1:0]  case_idx;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } cell_t;

  // typed marks a row whose case is written in by hand
  typedef struct packed {
    sample_t     s;
    logic        typed;
    logic [3:0]  want_case;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  pix_t                cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  pix_t                red;
  pix_t                green;
  pix_t                blue;
  logic                row_end;
  logic                grid_end_row;
  logic                out_valid;
  logic                out_ready;
  logic [CASE_W-1:0]   case_index;
  logic [COORD_W-1:0]  cell_row;
  logic [COORD_W-1:0]  cell_col;

  // predictor state
  logic        upper_bits [MAX_GRID_COLS_DEF];
  logic        left_b;
  logic        ul_bit;
  int          col_cnt;
  int          row_cnt;
  pix_t        grid_thr;

  cell_t       pending_cells [$];
  int          mismatches;
  int          cycle_count;
  int          items_sent;
  bit          burst_mode;
  bit          hold_req;

  // threshold plan per phase, -1 picks a random level
  int thr_plan [8] = '{0, 255, -1, 1, 254, -1, -1, 128};

  // grid A 3x3 mixed, grid B 3x2 dark, grid C 2x2 bright
  dir_row_t directed_rows [19] = '{
    '{'{8'd255, 8'd255, 8'd255, 1'b0, 1'b0}, 1'b0, 4'd0},
    '{'{8'd0,   8'd0,   8'd0,   1'b0, 1'b0}, 1'b0, 4'd0},
    '{'{8'd128, 8'd128, 8'd128, 1'b1, 1'b0}, 1'b0, 4'd0},
    '{'{8'd129, 8'd129, 8'd130, 1'b0, 1'b0}, 1'b0, 4'd0},
    '{'{8'd129, 8'd129, 8'd128, 1'b0, 1'b0}, 1'b1, 4'd6},
    '{'{8'd255, 8'd255, 8'd255, 1'b1, 1'b0}, 1'b1, 4'd13},
    '{'{8'd0,   8'd255, 8'd0,   1'b0, 1'b1}, 1'b0, 4'd0},
    '{'{8'd0,   8'd0,   8'd255, 1'b0, 1'b1}, 1'b1, 4'd7},
    '{'{8'd0,   8'd0,   8'd0,   1'b1, 1'b1}, 1'b1, 4'd9},
    '{'{8'd0,   8'd0,   8'd0,   1'b0, 1'b0}, 1'b0, 4'd0},
    '{'{8'd0,   8'd0,   8'd0,   1'b0, 1'b0}, 1'b0, 4'd0},
    '{'{8'd0,   8'd0,   8'd0,   1'b1, 1'b0}, 1'b0, 4'd0},
    '{'{8'd0,   8'd0,   8'd0,   1'b0, 1'b1}, 1'b0, 4'd0},
    '{'{8'd0,   8'd0,   8'd0,   1'b0, 1'b1}, 1'b1, 4'd15},
    '{'{8'd0,   8'd0,   8'd0,   1'b1, 1'b1}, 1'b1, 4'd13},
    '{'{8'd255, 8'd255, 8'd255, 1'b0, 1'b0}, 1'b0, 4'd0},
    '{'{8'd255, 8'd255, 8'd255, 1'b1, 1'b0}, 1'b0, 4'd0},
    '{'{8'd255, 8'd255, 8'd255, 1'b0, 1'b1}, 1'b0, 4'd0},
    '{'{8'd255, 8'd255, 8'd255, 1'b1, 1'b1}, 1'b1, 4'd0}
  };

  marching_squares_cell_classifier DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .row_end      (row_end),
    .grid_end_row (grid_end_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .case_index   (case_index),
    .cell_row     (cell_row),
    .cell_col     (cell_col)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Advance the grid model by one sample; returns 1 when a cell is classified.
  function automatic bit grid_step(input sample_t s, output cell_t res);
    int   gray;
    int   col;
    int   row;
    logic b;
    logic above;
    bit   made;
    gray  = (int'(s.red) + int'(s.green) + int'(s.blue)) / 3;
    b     = (gray > int'(grid_thr)) ? 1'b0 : 1'b1;
    col   = (col_cnt >= MAX_GRID_COLS_DEF) ? MAX_GRID_COLS_DEF - 1 : col_cnt;
    row   = row_cnt;
    // bottom-right grid corner is always outside
    if (s.row_end && s.last_row) b = 1'b0;
    above = upper_bits[col];
    made  = (row > 0) && (col > 0);
    res.case_idx = {ul_bit, above, b, left_b};
    res.row      = COORD_W'(row - 1);
    res.col      = COORD_W'(col - 1);
    ul_bit          = above;
    upper_bits[col] = b;
    left_b          = b;
    if (s.row_end) begin
      col_cnt = 0;
      if (s.last_row) row_cnt = 0;
      else if (row + 1 < MAX_GRID_ROWS_DEF) row_cnt = row + 1;
      else row_cnt = MAX_GRID_ROWS_DEF - 1;
    end else begin
      col_cnt = (col + 1 < MAX_GRID_COLS_DEF) ? col + 1 : MAX_GRID_COLS_DEF - 1;
    end
    return made;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // mix of full-range, near-threshold and saturated channels
  function automatic pix_t channel_value(int mode);
    int v;
    if (mode < 4) return pix_t'($urandom_range(0, 255));
    if (mode < 8) begin
      v = int'(grid_thr) + int'($urandom_range(0, 8)) - 4;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return pix_t'(v);
    end
    return $urandom_range(0, 1) ? 8'd255 : 8'd0;
  endfunction

  function automatic sample_t random_pixel();
    sample_t s;
    int      mode;
    mode       = $urandom_range(0, 9);
    s.red      = channel_value(mode);
    s.green    = channel_value(mode);
    s.blue     = channel_value(mode);
    s.row_end  = 1'b0;
    s.last_row = 1'b0;
    return s;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_SHOWN)
      $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  task automatic offer_sample(input sample_t s, input logic typed, input logic [3:0] want);
    cell_t res;
    bit    made;
    int    gap;
    in_valid     <= 1'b1;
    red          <= s.red;
    green        <= s.green;
    blue         <= s.blue;
    row_end      <= s.row_end;
    grid_end_row <= s.last_row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    made = grid_step(s, res);
    if (typed) res.case_idx = want;
    if (made || typed) pending_cells.push_back(res);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One grid row; noisy rows get the odd broken row_end / grid_end_row flag.
  task automatic feed_row(input int len, input bit last, input bit noisy);
    sample_t s;
    for (int i = 0; i < len; i++) begin
      s          = random_pixel();
      s.row_end  = (i == len - 1);
      s.last_row = last;
      if (noisy && $urandom_range(0, 9) == 0) begin
        s.row_end  = $urandom_range(0, 1);
        s.last_row = $urandom_range(0, 1);
      end
      offer_sample(s, 1'b0, 4'd0);
    end
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    // trailing samples may still be in the pipe without a result
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input pix_t level);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= level;
    @(posedge clk);
    cfg_we    <= 1'b0;
    grid_thr  = level;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int run_left;
    int r;
    out_ready = 1'b0;
    run_left  = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (hold_req) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
          run_left = 0;
        end else if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 60) begin
            out_ready <= 1'b1;
            run_left  = $urandom_range(0, 19);
          end else if (r < 92) begin
            out_ready <= 1'b0;
            run_left  = $urandom_range(0, 2);
          end else begin
            out_ready <= 1'b0;
            run_left  = $urandom_range(3, 29);
          end
        end else begin
          run_left--;
        end
      end
    end
  end

  always @(posedge clk) begin
    cell_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        flag_mismatch("unexpected cell request, case", case_index, 0);
      end else begin
        want = pending_cells.pop_front();
        if (case_index !== want.case_idx) flag_mismatch("case_index", case_index, want.case_idx);
        if (cell_row !== want.row) flag_mismatch("cell_row", cell_row, want.row);
        if (cell_col !== want.col) flag_mismatch("cell_col", cell_col, want.col);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("marching_squares_cell_classifier test failed");
      $finish;
    end
  end

  initial begin
    int rows;
    int cols;
    int phase_start;
    bit ragged;
    bit noisy;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    red          = '0;
    green        = '0;
    blue         = '0;
    row_end      = 1'b0;
    grid_end_row = 1'b0;
    items_sent   = 0;
    burst_mode   = 1'b0;
    hold_req     = 1'b0;
    foreach (upper_bits[i]) upper_bits[i] = 1'b0;
    left_b   = 1'b0;
    ul_bit   = 1'b0;
    col_cnt  = 0;
    row_cnt  = 0;
    grid_thr = THRESHOLD_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want_case);

    for (int phase = 0; phase < 8; phase++) begin
      write_threshold((thr_plan[phase] < 0) ? pix_t'($urandom_range(0, 255))
                                            : pix_t'(thr_plan[phase]));
      burst_mode = (phase == 4);
      if (phase == 1) begin
        // long output hold-off while a back-to-back stream keeps coming
        hold_req   = 1'b1;
        burst_mode = 1'b1;
        repeat (4) feed_row(8, 1'b0, 1'b0);
        feed_row(8, 1'b1, 1'b0);
        burst_mode = 1'b0;
      end
      if (phase == 2) begin
        // an overlong row under a short one, so its tail sits in the last column
        feed_row(4, 1'b0, 1'b0);
        feed_row(MAX_GRID_COLS_DEF + 6, 1'b0, 1'b0);
        feed_row(3, 1'b1, 1'b0);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < 70) begin
        rows   = $urandom_range(1, 7);
        cols   = $urandom_range(1, 12);
        ragged = ($urandom_range(0, 4) == 0);
        noisy  = ($urandom_range(0, 3) == 0);
        for (int r = 0; r < rows; r++)
          feed_row(ragged ? $urandom_range(1, cols + 3) : cols, r == rows - 1, noisy);
      end
    end

    settle_idle();
    if (mismatches == 0) $display("marching_squares_cell_classifier test passed");
    else $display("marching_squares_cell_classifier test failed");
    $finish;
  end

endmodule
